// ===== src/ptc_pkg.sv =====
package ptc_pkg;

   // field widths
   localparam int CAL_W   = 16;
   localparam int RAW_W   = 24;
   localparam int PRESS_W = 23;
   localparam int TEMP_W  = 19;

   // register stages from accept to the output register
   localparam int NUM_STAGES = 11;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_C1 = 3'd0;
   localparam csr_index_type CSR_C2 = 3'd1;
   localparam csr_index_type CSR_C3 = 3'd2;
   localparam csr_index_type CSR_C4 = 3'd3;
   localparam csr_index_type CSR_C5 = 3'd4;
   localparam csr_index_type CSR_C6 = 3'd5;

   // calibration word reset values
   localparam logic [CAL_W-1:0] C1_RESET = 16'd34982;
   localparam logic [CAL_W-1:0] C2_RESET = 16'd36352;
   localparam logic [CAL_W-1:0] C3_RESET = 16'd20328;
   localparam logic [CAL_W-1:0] C4_RESET = 16'd22354;
   localparam logic [CAL_W-1:0] C5_RESET = 16'd26646;
   localparam logic [CAL_W-1:0] C6_RESET = 16'd26146;

   // temperature reference (20.00 C) and the very-low band edge offset
   // (first-order TEMP < -1500 means dev < -3500)
   localparam logic signed [20:0] TEMP_REF  = 21'sd2000;
   localparam logic signed [19:0] VLOW_BIAS = 20'sd3500;

endpackage

// ===== src/pressure_temperature_compensation_top.sv =====
// Pressure / temperature compensation, second-order scheme.
//
// Input channel (req_*): one word carries a raw 24-bit pressure conversion
// and a raw 24-bit temperature conversion. Output channel (rsp_*): one word
// per input word, compensated pressure in 0.1 mbar (23-bit signed) and
// temperature in 0.01 C (19-bit signed), both saturated.
// Both channels are valid/ready; a word moves when valid and ready are high.
//
// One word per cycle is accepted sustained while the receiver keeps
// rsp_ready high. The 11 stages each hold multiplies or wide add/compare
// logic; the final 24 x 40 bit product is split into two partial products
// and summed in the following stage.
//
// Each stage has its own valid bit. A stalled receiver holds the output
// register; upstream stages keep filling until every stage is full, then
// req_ready drops. Nothing is lost or repeated.
//
// Calibration words are written through csr_* (index 0..5 = C1..C6, other indexes ignored);
// the user must write them only while the pipeline is empty; the block does not enforce it.
// Synchronous reset clears all valid bits and loads the default calibration words.
module pressure_temperature_compensation_top
   import ptc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [RAW_W-1:0]          req_raw_pressure,
   input  logic [RAW_W-1:0]          req_raw_temperature,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [PRESS_W-1:0] rsp_pressure_tenth_mbar,
   output logic signed [TEMP_W-1:0]  rsp_temperature_centideg,
   input  logic                      csr_write_enable,
   input  csr_index_type             csr_index,
   input  logic [CAL_W-1:0]          csr_write_data
);

   // ---------------------------------------------------------------
   // calibration words
   // ---------------------------------------------------------------
   logic [CAL_W-1:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= C1_RESET;
         c2_ff <= C2_RESET;
         c3_ff <= C3_RESET;
         c4_ff <= C4_RESET;
         c5_ff <= C5_RESET;
         c6_ff <= C6_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_C1: c1_ff <= csr_write_data;
            CSR_C2: c2_ff <= csr_write_data;
            CSR_C3: c3_ff <= csr_write_data;
            CSR_C4: c4_ff <= csr_write_data;
            CSR_C5: c5_ff <= csr_write_data;
            CSR_C6: c6_ff <= csr_write_data;
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline control: stage k loads when it is empty or its word
   // moves on, so bubbles collapse behind a stalled output
   // ---------------------------------------------------------------
   logic [NUM_STAGES-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES-2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = adv[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = v_ff[NUM_STAGES-1];

   // ---------------------------------------------------------------
   // stage 1: dT = D2 - C5*2^8
   // ---------------------------------------------------------------
   logic [RAW_W-1:0]  s1_d1_ff;
   logic signed [24:0] s1_dt_ff, s1_dt_in;

   assign s1_dt_in = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, c5_ff, 8'd0});

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_d1_ff <= req_raw_pressure;
         s1_dt_ff <= s1_dt_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: products of dT
   // ---------------------------------------------------------------
   logic [RAW_W-1:0]   s2_d1_ff;
   logic signed [41:0] s2_c6dt_ff, s2_c6dt_in;
   logic signed [41:0] s2_c3dt_ff, s2_c3dt_in;
   logic signed [41:0] s2_c4dt_ff, s2_c4dt_in;
   logic signed [49:0] s2_sq;
   logic [48:0]        s2_dtsq_ff, s2_dtsq_in;

   always_comb begin
      s2_c6dt_in = $signed({1'b0, c6_ff}) * s1_dt_ff;
      s2_c3dt_in = $signed({1'b0, c3_ff}) * s1_dt_ff;
      s2_c4dt_in = $signed({1'b0, c4_ff}) * s1_dt_ff;
      s2_sq      = s1_dt_ff * s1_dt_ff;
      s2_dtsq_in = s2_sq[48:0];  // square is never negative, below 2^48
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_d1_ff   <= s1_d1_ff;
         s2_c6dt_ff <= s2_c6dt_in;
         s2_c3dt_ff <= s2_c3dt_in;
         s2_c4dt_ff <= s2_c4dt_in;
         s2_dtsq_ff <= s2_dtsq_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: first-order terms, band select, Ti
   // dev = TEMP - 2000 = trunc(C6*dT / 2^23)
   // ---------------------------------------------------------------
   logic [RAW_W-1:0]   s3_d1_ff;
   logic signed [18:0] s3_dev_ff, s3_dev_in;
   logic signed [19:0] s3_lo_ff, s3_lo_in;
   logic signed [34:0] s3_sens_ff, s3_sens_in;
   logic signed [35:0] s3_off_ff, s3_off_in;
   logic [16:0]        s3_ti_ff, s3_ti_in;
   logic               s3_hiband_ff, s3_hiband_in;
   logic               s3_vlow_ff, s3_vlow_in;
   logic signed [41:0] s3_t6, s3_t3, s3_t4;
   logic [49:0]        s3_dtsq3;

   always_comb begin
      // add 2^k - 1 to negatives so the shift truncates toward zero
      s3_t6 = s2_c6dt_ff + $signed({19'd0, {23{s2_c6dt_ff[41]}}});
      s3_t3 = s2_c3dt_ff + $signed({34'd0, {8{s2_c3dt_ff[41]}}});
      s3_t4 = s2_c4dt_ff + $signed({35'd0, {7{s2_c4dt_ff[41]}}});

      s3_dev_in  = s3_t6[41:23];
      s3_sens_in = 35'($signed(s3_t3[41:8])) + 35'($signed({1'b0, c1_ff, 15'd0}));
      s3_off_in  = 36'($signed(s3_t4[41:7])) + 36'($signed({1'b0, c2_ff, 16'd0}));

      s3_hiband_in = !s3_dev_in[18];
      s3_lo_in     = 20'(s3_dev_in) + VLOW_BIAS;  // TEMP + 1500
      s3_vlow_in   = s3_lo_in[19];

      // high: 2*dT^2/2^37, low: 3*dT^2/2^33
      s3_dtsq3 = {1'b0, s2_dtsq_ff} + {s2_dtsq_ff, 1'b0};
      s3_ti_in = s3_hiband_in ? 17'(s2_dtsq_ff[48:36]) : s3_dtsq3[49:33];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_d1_ff     <= s2_d1_ff;
         s3_dev_ff    <= s3_dev_in;
         s3_lo_ff     <= s3_lo_in;
         s3_sens_ff   <= s3_sens_in;
         s3_off_ff    <= s3_off_in;
         s3_ti_ff     <= s3_ti_in;
         s3_hiband_ff <= s3_hiband_in;
         s3_vlow_ff   <= s3_vlow_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: squares of the deviations, final temperature
   // ---------------------------------------------------------------
   logic [RAW_W-1:0]   s4_d1_ff;
   logic [33:0]        s4_devsq_ff, s4_devsq_in;
   logic [34:0]        s4_losq_ff, s4_losq_in;
   logic signed [20:0] s4_temp_ff, s4_temp_in;
   logic signed [34:0] s4_sens_ff;
   logic signed [35:0] s4_off_ff;
   logic               s4_hiband_ff, s4_vlow_ff;
   logic signed [37:0] s4_p_dev;
   logic signed [39:0] s4_p_lo;

   always_comb begin
      s4_p_dev    = s3_dev_ff * s3_dev_ff;
      s4_p_lo     = s3_lo_ff * s3_lo_ff;
      s4_devsq_in = s4_p_dev[33:0];
      s4_losq_in  = s4_p_lo[34:0];
      s4_temp_in  = 21'(s3_dev_ff) + TEMP_REF - 21'($signed({1'b0, s3_ti_ff}));
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_d1_ff     <= s3_d1_ff;
         s4_devsq_ff  <= s4_devsq_in;
         s4_losq_ff   <= s4_losq_in;
         s4_temp_ff   <= s4_temp_in;
         s4_sens_ff   <= s3_sens_ff;
         s4_off_ff    <= s3_off_ff;
         s4_hiband_ff <= s3_hiband_ff;
         s4_vlow_ff   <= s3_vlow_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: OFFi, SENSi; temperature saturation
   // ---------------------------------------------------------------
   logic [RAW_W-1:0]         s5_d1_ff;
   logic [37:0]              s5_offi_ff, s5_offi_in;
   logic [37:0]              s5_sensi_ff, s5_sensi_in;
   logic signed [34:0]       s5_sens_ff;
   logic signed [35:0]       s5_off_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff, s5_temp_in;
   logic [37:0]              s5_dev3, s5_dev5, s5_lo7, s5_lo4;

   always_comb begin
      s5_dev3 = 38'(s4_devsq_ff) + 38'({s4_devsq_ff, 1'b0});
      s5_dev5 = 38'(s4_devsq_ff) + 38'({s4_devsq_ff, 2'b00});
      s5_lo7  = 38'({s4_losq_ff, 3'b000}) - 38'(s4_losq_ff);
      s5_lo4  = 38'({s4_losq_ff, 2'b00});
      if (s4_hiband_ff) begin
         s5_offi_in  = 38'(s4_devsq_ff >> 4);
         s5_sensi_in = '0;
      end else begin
         s5_offi_in  = (s5_dev3 >> 1) + (s4_vlow_ff ? s5_lo7 : 38'd0);
         s5_sensi_in = (s5_dev5 >> 3) + (s4_vlow_ff ? s5_lo4 : 38'd0);
      end

      // in range when the top three bits agree
      if (s4_temp_ff[20:18] == 3'b000 || s4_temp_ff[20:18] == 3'b111) begin
         s5_temp_in = s4_temp_ff[TEMP_W-1:0];
      end else if (s4_temp_ff[20]) begin
         s5_temp_in = {1'b1, {(TEMP_W-1){1'b0}}};
      end else begin
         s5_temp_in = {1'b0, {(TEMP_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_d1_ff    <= s4_d1_ff;
         s5_offi_ff  <= s5_offi_in;
         s5_sensi_ff <= s5_sensi_in;
         s5_sens_ff  <= s4_sens_ff;
         s5_off_ff   <= s4_off_ff;
         s5_temp_ff  <= s5_temp_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 6: OFF2 = OFF - OFFi, SENS2 = SENS - SENSi
   // ---------------------------------------------------------------
   logic [RAW_W-1:0]         s6_d1_ff;
   logic signed [39:0]       s6_off_ff, s6_off_in;
   logic signed [39:0]       s6_sens_ff, s6_sens_in;
   logic signed [TEMP_W-1:0] s6_temp_ff;

   always_comb begin
      s6_off_in  = 40'(s5_off_ff) - 40'($signed({1'b0, s5_offi_ff}));
      s6_sens_in = 40'(s5_sens_ff) - 40'($signed({1'b0, s5_sensi_ff}));
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_d1_ff   <= s5_d1_ff;
         s6_off_ff  <= s6_off_in;
         s6_sens_ff <= s6_sens_in;
         s6_temp_ff <= s5_temp_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 7: D1 * SENS2 as two partial products (low 20 bits unsigned,
   // high 20 bits signed)
   // ---------------------------------------------------------------
   logic [43:0]              s7_pp_lo_ff, s7_pp_lo_in;
   logic signed [44:0]       s7_pp_hi_ff, s7_pp_hi_in;
   logic signed [39:0]       s7_off_ff;
   logic signed [TEMP_W-1:0] s7_temp_ff;

   always_comb begin
      s7_pp_lo_in = s6_d1_ff * s6_sens_ff[19:0];
      s7_pp_hi_in = $signed({1'b0, s6_d1_ff}) * $signed(s6_sens_ff[39:20]);
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s7_pp_lo_ff <= s7_pp_lo_in;
         s7_pp_hi_ff <= s7_pp_hi_in;
         s7_off_ff   <= s6_off_ff;
         s7_temp_ff  <= s6_temp_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 8: sum partial products
   // ---------------------------------------------------------------
   logic signed [63:0]       s8_prod_ff, s8_prod_in;
   logic signed [39:0]       s8_off_ff;
   logic signed [TEMP_W-1:0] s8_temp_ff;

   assign s8_prod_in = (64'(s7_pp_hi_ff) <<< 20) + $signed({20'd0, s7_pp_lo_ff});

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s8_prod_ff <= s8_prod_in;
         s8_off_ff  <= s7_off_ff;
         s8_temp_ff <= s7_temp_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 9: trunc(D1*SENS2 / 2^21)
   // ---------------------------------------------------------------
   logic signed [42:0]       s9_q_ff;
   logic signed [63:0]       s9_t;
   logic signed [39:0]       s9_off_ff;
   logic signed [TEMP_W-1:0] s9_temp_ff;

   assign s9_t = s8_prod_ff + $signed({43'd0, {21{s8_prod_ff[63]}}});

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s9_q_ff    <= s9_t[63:21];
         s9_off_ff  <= s8_off_ff;
         s9_temp_ff <= s8_temp_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 10: minus OFF2
   // ---------------------------------------------------------------
   logic signed [43:0]       s10_diff_ff, s10_diff_in;
   logic signed [TEMP_W-1:0] s10_temp_ff;

   assign s10_diff_in = 44'(s9_q_ff) - 44'(s9_off_ff);

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         s10_diff_ff <= s10_diff_in;
         s10_temp_ff <= s9_temp_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 11 (output register): trunc(/ 2^13), saturate
   // ---------------------------------------------------------------
   logic signed [43:0]        s11_t;
   logic signed [30:0]        s11_p;
   logic signed [PRESS_W-1:0] s11_press_ff, s11_press_in;
   logic signed [TEMP_W-1:0]  s11_temp_ff;

   always_comb begin
      s11_t = s10_diff_ff + $signed({31'd0, {13{s10_diff_ff[43]}}});
      s11_p = s11_t[43:13];
      if (s11_p[30:22] == 9'h000 || s11_p[30:22] == 9'h1ff) begin
         s11_press_in = s11_p[PRESS_W-1:0];
      end else if (s11_p[30]) begin
         s11_press_in = {1'b1, {(PRESS_W-1){1'b0}}};
      end else begin
         s11_press_in = {1'b0, {(PRESS_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[10]) begin
         s11_press_ff <= s11_press_in;
         s11_temp_ff  <= s10_temp_ff;
      end
   end

   assign rsp_pressure_tenth_mbar  = s11_press_ff;
   assign rsp_temperature_centideg = s11_temp_ff;

`ifndef SYNTH
   // input backpressure only when every stage holds a word
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&v_ff))
      else $error("req_ready low with an empty stage");

   // an accept without a delivery adds exactly one word in flight
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !(rsp_valid && rsp_ready))
      |=> ($countones(v_ff) == $past($countones(v_ff)) + 1))
      else $error("word lost or duplicated in pipeline");

   // high band: small Ti and never the very-low band
   a_band: assert property (@(posedge clock) disable iff (reset)
      (v_ff[2] && s3_hiband_ff) |-> (s3_ti_ff[16:13] == 4'd0 && !s3_vlow_ff))
      else $error("band select inconsistent");
`endif

endmodule

// ===== bench/pressure_temperature_compensation_top_tb.sv =====
`timescale 1ns / 1ps

module pressure_temperature_compensation_top_tb
   import ptc_pkg::*;
();

   // Watchdog: cycles with work pending but no word moving on either channel.
   // The slowest correct stretch is the receiver hold-off below plus a few
   // short stalls, so this is many times over.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 200;
   localparam int PHASE_WORDS    = 80;
   localparam int PRESSURE_WORDS = 60;
   localparam int STREAM_WORDS   = 60;
   localparam int NUM_CAL        = 6;

   // indexes past C6 decode to nothing
   localparam csr_index_type CSR_SPARE_6 = 3'd6;
   localparam csr_index_type CSR_SPARE_7 = 3'd7;

   localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
   localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

   localparam longint PRESS_LOW  = -4194304;
   localparam longint PRESS_HIGH = 4194303;
   localparam longint TEMP_LOW   = -262144;
   localparam longint TEMP_HIGH  = 262143;

   // one expected result word, with the raw inputs kept for the report
   typedef struct packed {
      logic [RAW_W-1:0]   raw_pressure;
      logic [RAW_W-1:0]   raw_temperature;
      logic [PRESS_W-1:0] pressure;
      logic [TEMP_W-1:0]  temperature;
   } reading_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [RAW_W-1:0]          req_raw_pressure;
   logic [RAW_W-1:0]          req_raw_temperature;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [PRESS_W-1:0] rsp_pressure_tenth_mbar;
   logic signed [TEMP_W-1:0]  rsp_temperature_centideg;
   logic                      csr_write_enable;
   csr_index_type             csr_index;
   logic [CAL_W-1:0]          csr_write_data;

   // bench copy of the calibration words
   logic [CAL_W-1:0] cal_word [NUM_CAL];

   reading_type expected_readings[$];
   int          words_checked;
   int          mismatch_count;
   int          cal_settings;
   int          hold_requests;
   bit          idle_on;

   pressure_temperature_compensation_top dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_raw_pressure         (req_raw_pressure),
      .req_raw_temperature      (req_raw_temperature),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_pressure_tenth_mbar  (rsp_pressure_tenth_mbar),
      .rsp_temperature_centideg (rsp_temperature_centideg),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data)
   );

   // 2 ns clock, rising edges at odd ns
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Compensation predictor. All math in signed 64 bits; SV division on
   // signed operands truncates toward zero, same as the scheme requires.
   // ------------------------------------------------------------------
   function automatic reading_type compensate_reading(logic [RAW_W-1:0] d1_raw,
                                                      logic [RAW_W-1:0] d2_raw);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, ti, offi, sensi, dev, cold, p;
      reading_type r;
      d1 = longint'(d1_raw);
      d2 = longint'(d2_raw);
      c1 = longint'(cal_word[CSR_C1]);
      c2 = longint'(cal_word[CSR_C2]);
      c3 = longint'(cal_word[CSR_C3]);
      c4 = longint'(cal_word[CSR_C4]);
      c5 = longint'(cal_word[CSR_C5]);
      c6 = longint'(cal_word[CSR_C6]);

      // first order
      dt   = d2 - c5 * 256;
      temp = 2000 + (c6 * dt) / 8388608;
      sens = c1 * 32768 + (c3 * dt) / 256;
      off  = c2 * 65536 + (c4 * dt) / 128;

      // second order: high band at 20.00 C and up, else low band, with the
      // very-low term added below -15.00 C
      dev = temp - 2000;
      if (temp >= 2000) begin
         ti    = (2 * dt * dt) / 64'sd137438953472;
         offi  = (dev * dev) / 16;
         sensi = 0;
      end else begin
         ti    = (3 * dt * dt) / 64'sd8589934592;
         offi  = (3 * dev * dev) / 2;
         sensi = (5 * dev * dev) / 8;
         if (temp < -1500) begin
            cold  = temp + 1500;
            offi  = offi + 7 * cold * cold;
            sensi = sensi + 4 * cold * cold;
         end
      end

      off  = off - offi;
      sens = sens - sensi;
      p    = ((d1 * sens) / 2097152 - off) / 8192;
      temp = temp - ti;

      // saturate, then keep the field bits
      if (p < PRESS_LOW) p = PRESS_LOW;
      if (p > PRESS_HIGH) p = PRESS_HIGH;
      if (temp < TEMP_LOW) temp = TEMP_LOW;
      if (temp > TEMP_HIGH) temp = TEMP_HIGH;

      r.raw_pressure    = d1_raw;
      r.raw_temperature = d2_raw;
      r.pressure        = p[PRESS_W-1:0];
      r.temperature     = temp[TEMP_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result checker: every word taken off rsp_* is matched against the
   // oldest prediction. Sampled at the rising edge, so it sees the values
   // the handshake was decided on.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_checker
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: result word with none expected: pressure %0d, temperature %0d",
                     $time, rsp_pressure_tenth_mbar, rsp_temperature_centideg);
            mismatch_count++;
         end else begin
            want = expected_readings.pop_front();
            words_checked++;
            if (rsp_pressure_tenth_mbar !== want.pressure) begin
               $display("%0t: pressure mismatch (D1 %0d, D2 %0d): expected %0d, actual %0d",
                        $time, want.raw_pressure, want.raw_temperature,
                        $signed(want.pressure), rsp_pressure_tenth_mbar);
               mismatch_count++;
            end
            if (rsp_temperature_centideg !== want.temperature) begin
               $display("%0t: temperature mismatch (D1 %0d, D2 %0d): expected %0d, actual %0d",
                        $time, want.raw_pressure, want.raw_temperature,
                        $signed(want.temperature), rsp_temperature_centideg);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls while idle_on; a long hold-off when the test asks
   // for one, counted down here.
   // ------------------------------------------------------------------
   initial begin : receiver
      int stall_left;
      int hold_left;
      int holds_served;
      rsp_ready    = 1'b0;
      stall_left   = 0;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: only counts while something is offered or outstanding.
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else if (req_valid || expected_readings.size() != 0)
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_readings.size());
            $display("FAIL pressure_temperature_compensation_top");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender. Valid stays up across back-to-back words; it only drops for an
   // idle burst or when a test stops sending.
   // ------------------------------------------------------------------
   task automatic send_reading(input logic [RAW_W-1:0] raw_p,
                               input logic [RAW_W-1:0] raw_t);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      req_raw_pressure    <= raw_p;
      req_raw_temperature <= raw_t;
      req_valid           <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_readings.push_back(compensate_reading(raw_p, raw_t));
   endtask

   // drop valid and let the pipeline empty out; calibration writes only
   // happen after this
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_cal(input csr_index_type index, input logic [CAL_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index < NUM_CAL) cal_word[index] = data;
   endtask

   task automatic load_calibration(input logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6);
      wait_drained();
      write_cal(CSR_C1, c1);
      write_cal(CSR_C2, c2);
      write_cal(CSR_C3, c3);
      write_cal(CSR_C4, c4);
      write_cal(CSR_C5, c5);
      write_cal(CSR_C6, c6);
      cal_settings++;
   endtask

   // Random raw words. D2 is often placed around the reference temperature
   // (C5 * 256) so all three bands show up under most calibrations.
   task automatic send_random_readings(input int count);
      logic [RAW_W-1:0] raw_p;
      logic [RAW_W-1:0] raw_t;
      longint           near_ref;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 3))
            0, 1: raw_t = RAW_W'($urandom_range(0, RAW_MAX));
            2: begin
               near_ref = longint'(cal_word[CSR_C5]) * 256
                          + longint'($urandom_range(0, 3000000)) - 1500000;
               if (near_ref < 0) near_ref = 0;
               if (near_ref > longint'(RAW_MAX)) near_ref = longint'(RAW_MAX);
               raw_t = near_ref[RAW_W-1:0];
            end
            default: raw_t = ($urandom_range(0, 1) == 1) ? RAW_MAX : '0;
         endcase
         case ($urandom_range(0, 7))
            0: raw_p = '0;
            1: raw_p = RAW_MAX;
            default: raw_p = RAW_W'($urandom_range(0, RAW_MAX));
         endcase
         send_reading(raw_p, raw_t);
      end
   endtask

   function automatic logic [CAL_W-1:0] corner_cal();
      return ($urandom_range(0, 1) == 1) ? CAL_MAX : '0;
   endfunction

   function automatic logic [CAL_W-1:0] random_cal();
      return CAL_W'($urandom_range(0, CAL_MAX));
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // reset calibration: field extremes and a typical sample
   task automatic test_reset_calibration();
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(RAW_MAX, '0);
      send_reading('0, RAW_MAX);
      send_reading(24'd4958179, 24'd6815414);
      send_reading(24'h555555, 24'hAAAAAA);
      send_reading(24'hAAAAAA, 24'h555555);
   endtask

   // band edges under the reset calibration (reference D2 is 6821376):
   // first-order TEMP exactly 20.00 C (with D2 at and one above the reference),
   // just under it, exactly -15.00 C, just under that, and one well inside each band
   task automatic test_temperature_bands();
      send_reading(24'd5000000, 24'd6821376);
      send_reading(24'd5000000, 24'd6821377);
      send_reading(24'd5000000, 24'd6821055);
      send_reading(24'd5000000, 24'd5698445);
      send_reading(24'd5000000, 24'd5698124);
      send_reading(24'd5000000, 24'd8000000);
      send_reading(24'd5000000, 24'd6000000);
      send_reading(24'd5000000, 24'd3000000);
   endtask

   // all-zero and all-one calibration, then one where pressure saturates high;
   // all-one with D2 at zero saturates it low
   task automatic test_calibration_extremes();
      load_calibration('0, '0, '0, '0, '0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading('0, 24'h800000);
      load_calibration(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(RAW_MAX, '0);
      send_reading('0, '0);
      load_calibration(CAL_MAX, '0, CAL_MAX, '0, '0, '0);
      send_reading(RAW_MAX, RAW_MAX);
   endtask

   // writes past C6 must leave the calibration alone
   task automatic test_ignored_indexes();
      load_calibration(C1_RESET, C2_RESET, C3_RESET, C4_RESET, C5_RESET, C6_RESET);
      write_cal(CSR_SPARE_6, random_cal());
      write_cal(CSR_SPARE_7, random_cal());
      send_reading(24'd4958179, 24'd6815414);
      send_reading(24'd9000000, 24'd3000000);
   endtask

   // random words under reset, random and corner calibrations
   task automatic test_random_calibrations();
      send_random_readings(PHASE_WORDS);
      load_calibration(random_cal(), random_cal(), random_cal(),
                       random_cal(), random_cal(), random_cal());
      send_random_readings(PHASE_WORDS);
      load_calibration(corner_cal(), corner_cal(), corner_cal(),
                       corner_cal(), corner_cal(), corner_cal());
      send_random_readings(PHASE_WORDS);
      load_calibration(random_cal(), random_cal(), random_cal(),
                       random_cal(), random_cal(), random_cal());
      send_random_readings(PHASE_WORDS);
   endtask

   // receiver holds off while the sender keeps offering: every stage fills
   // and req_ready has to drop without losing a word
   task automatic test_backpressure();
      hold_requests++;
      send_random_readings(PRESSURE_WORDS);
   endtask

   // no idling on either side: one word per cycle through the pipeline
   task automatic test_steady_stream();
      load_calibration(C1_RESET, C2_RESET, C3_RESET, C4_RESET, C5_RESET, C6_RESET);
      send_random_readings(STREAM_WORDS);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_raw_pressure    = '0;
      req_raw_temperature = '0;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_C1;
      csr_write_data      = '0;
      idle_on             = 1'b1;
      words_checked       = 0;
      mismatch_count      = 0;
      cal_settings        = 1;
      hold_requests       = 0;
      cal_word[CSR_C1]    = C1_RESET;
      cal_word[CSR_C2]    = C2_RESET;
      cal_word[CSR_C3]    = C3_RESET;
      cal_word[CSR_C4]    = C4_RESET;
      cal_word[CSR_C5]    = C5_RESET;
      cal_word[CSR_C6]    = C6_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_calibration();
      test_temperature_bands();
      test_calibration_extremes();
      test_ignored_indexes();
      test_random_calibrations();
      test_backpressure();

      // last stretch runs without idling
      idle_on = 1'b0;
      test_steady_stream();

      // drain, then a few pipeline depths of quiet to catch stray words
      wait_drained();
      repeat (4 * NUM_STAGES) @(posedge clock);

      $display("Checked %0d result words under %0d calibration settings (reset, zero, all-one,",
               words_checked, cal_settings);
      $display("corner and random), band edges, ignored indexes and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("PASS pressure_temperature_compensation_top");
      end else begin
         $display("FAIL pressure_temperature_compensation_top");
      end
      $finish;
   end

endmodule

// ===== pressure_temperature_compensation_top.f =====
src/ptc_pkg.sv
src/pressure_temperature_compensation_top.sv
bench/pressure_temperature_compensation_top_tb.sv
